@@ rtl/length_prefixed_deframer_unit_assert.svh @@
// Assertion macros for the length-prefixed deframer.
// LPD_ASSERT checks a property at every rising clock edge outside reset.
// LPD_ASSERT_NEXT checks that a condition leads to another in the next cycle.
`ifndef LENGTH_PREFIXED_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define LPD_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define LPD_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`else

`define LPD_ASSERT(name, clk, rstn, prop, msg)

`define LPD_ASSERT_NEXT(name, clk, rstn, pre, post, msg)

`endif

`endif

@@ rtl/lpd_pkg.sv @@
`default_nettype none

package lpd_pkg;

  // Frame parsing phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DROP   = 2'd2
  } phase_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BODY     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_TIMEOUT  = 2'd2,
    KIND_OVERSIZE = 2'd3
  } kind_e;

  // Input commands
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_IDLE_LIMIT   = 1'b0,
    CFG_MAX_BODY_LEN = 1'b1
  } cfg_reg_e;

  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned HDR_CNT_W  = 3;
  localparam int unsigned HDR_W      = 64;
  localparam int unsigned LEN_W      = 31;

  localparam logic [7:0]       IDLE_LIMIT_RST = 8'd11;
  localparam logic [LEN_W-1:0] MAX_BODY_RST   = 31'd4088;
  localparam logic [7:0]       IDLE_SAT       = 8'hFF;

  // One result item
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  body_byte;
    logic [31:0] message_id;
    logic [31:0] body_length;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/lpd_core.sv @@
`default_nettype none

`include "length_prefixed_deframer_unit_assert.svh"

module lpd_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_fire_i,
  input  wire logic                          command_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [lpd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                               res_valid_o,
  output lpd_pkg::res_t                      res_o
);

  lpd_pkg::phase_e                  phase_q, phase_d;
  logic [lpd_pkg::HDR_CNT_W-1:0]    hdr_cnt_q, hdr_cnt_d;
  logic [lpd_pkg::HDR_W-1:0]        hdr_q, hdr_d;
  logic [lpd_pkg::LEN_W-1:0]        body_rem_q, body_rem_d;
  logic [7:0]                       idle_q, idle_d;
  logic                             seen_q, seen_d;
  logic                             to_rep_q, to_rep_d;
  logic [7:0]                       idle_limit_q;
  logic [lpd_pkg::LEN_W-1:0]        max_len_q;

  logic [lpd_pkg::HDR_W-1:0]        hdr_new;
  logic [7:0]                       idle_inc;
  logic                             body_fin;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= lpd_pkg::IDLE_LIMIT_RST;
      max_len_q    <= lpd_pkg::MAX_BODY_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lpd_pkg::CFG_IDLE_LIMIT) begin
        idle_limit_q <= cfg_wdata_i[7:0];
      end else begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  // Header with the incoming byte placed at the current position
  always_comb begin
    hdr_new = hdr_q;
    hdr_new[{hdr_cnt_q, 3'b000} +: 8] = data_byte_i;
  end

  assign idle_inc = (idle_q == lpd_pkg::IDLE_SAT) ? idle_q : idle_q + 8'd1;
  assign body_fin = (body_rem_q <= 31'd1);

  // Next state and result for one accepted item
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    hdr_d       = hdr_q;
    body_rem_d  = body_rem_q;
    idle_d      = idle_q;
    seen_d      = seen_q;
    to_rep_d    = to_rep_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: lpd_pkg::KIND_BODY, body_byte: 8'd0, message_id: hdr_q[63:32],
                    body_length: hdr_q[31:0], last: 1'b0};

    if (in_fire_i) begin
      if (command_i == lpd_pkg::CMD_TICK) begin
        // Count idle seconds once the stream has started
        if (seen_q && !to_rep_q) begin
          idle_d = idle_inc;
          if (idle_inc >= idle_limit_q) begin
            to_rep_d    = 1'b1;
            res_valid_o = 1'b1;
            res_o       = '{kind: lpd_pkg::KIND_TIMEOUT, body_byte: 8'd0,
                            message_id: 32'd0, body_length: 32'd0, last: 1'b1};
          end
        end
      end else begin
        seen_d   = 1'b1;
        idle_d   = 8'd0;
        to_rep_d = 1'b0;
        case (phase_q)
          lpd_pkg::PH_HEADER: begin
            hdr_d     = hdr_new;
            hdr_cnt_d = hdr_cnt_q + 3'd1;
            if (hdr_cnt_q == 3'd7) begin
              res_o.message_id  = hdr_new[63:32];
              res_o.body_length = hdr_new[31:0];
              res_o.last        = 1'b1;
              if (hdr_new[31:0] > {1'b0, max_len_q}) begin
                // Oversize: drop everything from here on
                phase_d     = lpd_pkg::PH_DROP;
                res_valid_o = 1'b1;
                res_o.kind  = lpd_pkg::KIND_OVERSIZE;
              end else if (hdr_new[31:0] == 32'd0) begin
                res_valid_o = 1'b1;
                res_o.kind  = lpd_pkg::KIND_EMPTY;
              end else begin
                body_rem_d = hdr_new[lpd_pkg::LEN_W-1:0];
                phase_d    = lpd_pkg::PH_BODY;
              end
            end
          end
          lpd_pkg::PH_BODY: begin
            res_valid_o     = 1'b1;
            res_o.body_byte = data_byte_i;
            res_o.last      = body_fin;
            if (body_fin) begin
              body_rem_d = '0;
              phase_d    = lpd_pkg::PH_HEADER;
            end else begin
              body_rem_d = body_rem_q - 31'd1;
            end
          end
          default: begin
            // Dropping: byte only counts as activity
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= lpd_pkg::PH_HEADER;
      hdr_cnt_q  <= '0;
      hdr_q      <= '0;
      body_rem_q <= '0;
      idle_q     <= '0;
      seen_q     <= 1'b0;
      to_rep_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      hdr_q      <= hdr_d;
      body_rem_q <= body_rem_d;
      idle_q     <= idle_d;
      seen_q     <= seen_d;
      to_rep_q   <= to_rep_d;
    end
  end

  `LPD_ASSERT(a_hdr_cnt_in_header, clk_i, rst_ni,
              (hdr_cnt_q == 3'd0) || (phase_q == lpd_pkg::PH_HEADER),
              "header count advanced outside header phase")
  `LPD_ASSERT(a_body_rem_nonzero, clk_i, rst_ni,
              (phase_q != lpd_pkg::PH_BODY) || (body_rem_q != 31'd0),
              "body phase with nothing left to send")
  `LPD_ASSERT(a_timeout_needs_activity, clk_i, rst_ni,
              !to_rep_q || seen_q, "timeout reported before any byte")
  `LPD_ASSERT_NEXT(a_drop_sticks, clk_i, rst_ni,
                   phase_q == lpd_pkg::PH_DROP, phase_q == lpd_pkg::PH_DROP,
                   "left dropping phase without reset")

endmodule

`default_nettype wire

@@ rtl/lpd_out_buf.sv @@
`default_nettype none

`include "length_prefixed_deframer_unit_assert.svh"

module lpd_out_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lpd_pkg::res_t push_data_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output lpd_pkg::res_t      out_data_o
);

  lpd_pkg::res_t main_q, main_d;
  lpd_pkg::res_t skid_q, skid_d;
  logic          main_v_q, main_v_d;
  logic          skid_v_q, skid_v_d;
  logic          pop;

  assign pop         = main_v_q && out_ready_i;
  assign space_o     = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  // Refill the output register from the skid stage first, then from a new result
  always_comb begin
    main_d   = main_q;
    main_v_d = main_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (!main_v_q || pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        main_v_d = 1'b1;
        skid_v_d = push_i;
        skid_d   = push_i ? push_data_i : skid_q;
      end else begin
        main_d   = push_data_i;
        main_v_d = push_i;
      end
    end else if (push_i) begin
      skid_d   = push_data_i;
      skid_v_d = 1'b1;
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  `LPD_ASSERT(a_skid_implies_main, clk_i, rst_ni,
              !skid_v_q || main_v_q, "skid stage holds a result ahead of the output")
  `LPD_ASSERT(a_no_push_when_full, clk_i, rst_ni,
              !(push_i && skid_v_q), "result pushed with both stages full")
  `LPD_ASSERT_NEXT(a_skid_holds, clk_i, rst_ni,
                   skid_v_q && !pop, skid_v_q && $stable(skid_q),
                   "waiting skid result lost or changed")

endmodule

`default_nettype wire

@@ rtl/length_prefixed_deframer_unit.sv @@
`default_nettype none

// Length-prefixed message deframer. Each input transfer is either a stream byte or a
// one-second tick; frames are an 8-byte little-endian header (32-bit body length, then
// 32-bit message id) followed by the body, which leaves one body-byte result per byte,
// tagged with id and length and marked last on the final byte. Zero-length frames give
// one empty-message result, a length above max_body_len gives one oversize error after
// which all bytes are dropped until reset, and idle_limit ticks without a byte (once the
// stream has started) give one timeout result. One transfer is taken every cycle while
// in_ready_o is high; results go to a two-entry output stage (output and skid registers)
// that keeps input accepted while one result waits, so in_ready_o only drops when both
// entries are full. Configuration is written through cfg_we_i/cfg_index_i/cfg_wdata_i
// (index 0 idle_limit, 1 max_body_len) by the user while idle; the block does not check.
module length_prefixed_deframer_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_index_i,
  input  wire logic [lpd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           command_i,
  input  wire logic [7:0]                     data_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [1:0]                          kind_o,
  output logic [7:0]                          body_byte_o,
  output logic signed [31:0]                  message_id_o,
  output logic signed [31:0]                  body_length_o,
  output logic                                last_o
);

  logic          in_fire;
  logic          res_valid;
  logic          space;
  lpd_pkg::res_t res;
  lpd_pkg::res_t out_data;

  assign in_ready_o = space;
  assign in_fire    = in_valid_i && space;

  lpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  // Unpack the result onto the output ports
  assign kind_o        = out_data.kind;
  assign body_byte_o   = out_data.body_byte;
  assign message_id_o  = out_data.message_id;
  assign body_length_o = out_data.body_length;
  assign last_o        = out_data.last;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_TICK,
    ROW_CFG
  } row_op_e;

  // One line of the directed script
  typedef struct packed {
    row_op_e           op;
    lpd_pkg::cfg_reg_e reg_sel;
    logic [30:0]       arg;
    logic              typed;
    logic              hit;
    lpd_pkg::res_t     want;
  } row_t;

  localparam lpd_pkg::res_t NO_RES      = '0;
  localparam lpd_pkg::res_t EMPTY_RES   =
    '{lpd_pkg::KIND_EMPTY, 8'h00, 32'hFFFF_FFFF, 32'h0, 1'b1};
  localparam lpd_pkg::res_t TIMEOUT_RES =
    '{lpd_pkg::KIND_TIMEOUT, 8'h00, 32'h0, 32'h0, 1'b1};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_index_i = 1'b0;
  logic [lpd_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              command_i = 1'b0;
  logic [7:0]        data_byte_i = 8'h00;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        kind_o;
  logic [7:0]        body_byte_o;
  logic signed [31:0] message_id_o;
  logic signed [31:0] body_length_o;
  logic              last_o;

  // Deframer model state and its copy of the registers
  lpd_pkg::phase_e           st_phase = lpd_pkg::PH_HEADER;
  logic [2:0]                hdr_cnt = 3'd0;
  logic [63:0]               hdr = 64'h0;
  logic [lpd_pkg::LEN_W-1:0] body_left = '0;
  logic [7:0]                idle_cnt = 8'h00;
  logic                      seen_byte = 1'b0;
  logic                      timeout_sent = 1'b0;
  logic [7:0]                idle_lim = lpd_pkg::IDLE_LIMIT_RST;
  logic [lpd_pkg::LEN_W-1:0] max_len = lpd_pkg::MAX_BODY_RST;

  lpd_pkg::res_t     due_results[$];
  int unsigned       error_count = 0;
  int unsigned       fed_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       gap_pct = 0;
  int unsigned       stall_pct = 0;

  int unsigned       gap_modes[4]   = '{0, 76, 0, 22};
  int unsigned       stall_modes[4] = '{0, 0, 76, 22};
  int unsigned       lim_set[6]     = '{11, 255, 1, 0, 37, 5};
  int unsigned       max_set[6]     = '{4088, 32'h7FFF_FFFF, 3, 0, 64, 200};

  row_t script_rows [22] = '{
    // tick before any byte: nothing counted
    '{ROW_TICK, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b1, 1'b0, NO_RES},
    // zero length, all-ones id
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'hFF, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'hFF, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'hFF, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'hFF, 1'b1, 1'b1, EMPTY_RES},
    // two-byte body, id with only the sign bit set
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h02, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h80, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, lpd_pkg::CFG_IDLE_LIMIT, 31'hFF, 1'b0, 1'b0, NO_RES},
    // one idle second is enough, and a second tick stays quiet
    '{ROW_CFG,  lpd_pkg::CFG_IDLE_LIMIT, 31'h01, 1'b0, 1'b0, NO_RES},
    '{ROW_TICK, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b1, 1'b1, TIMEOUT_RES},
    '{ROW_TICK, lpd_pkg::CFG_IDLE_LIMIT, 31'h00, 1'b1, 1'b0, NO_RES}
  };

  length_prefixed_deframer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .body_byte_o   (body_byte_o),
    .message_id_o  (message_id_o),
    .body_length_o (body_length_o),
    .last_o        (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advance the deframer model by one transfer; return 1 when it yields a result
  function automatic bit deframe_step(input lpd_pkg::cmd_e c, input logic [7:0] b,
                                      output lpd_pkg::res_t r);
    logic [31:0] len;
    logic [31:0] id;
    r = '0;
    len = hdr[31:0];
    id = hdr[63:32];
    if (c == lpd_pkg::CMD_TICK) begin
      if (!seen_byte || timeout_sent) return 1'b0;
      if (idle_cnt != lpd_pkg::IDLE_SAT) idle_cnt = idle_cnt + 8'd1;
      if (idle_cnt >= idle_lim) begin
        timeout_sent = 1'b1;
        r.kind = lpd_pkg::KIND_TIMEOUT;
        r.last = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    seen_byte = 1'b1;
    idle_cnt = 8'h00;
    timeout_sent = 1'b0;
    case (st_phase)
      lpd_pkg::PH_HEADER: begin
        hdr[{hdr_cnt, 3'b000} +: 8] = b;
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt != 3'd0) return 1'b0;
        len = hdr[31:0];
        id = hdr[63:32];
        r.message_id = id;
        r.body_length = len;
        r.last = 1'b1;
        if (len > {1'b0, max_len}) begin
          st_phase = lpd_pkg::PH_DROP;
          r.kind = lpd_pkg::KIND_OVERSIZE;
          return 1'b1;
        end
        if (len == 32'h0) begin
          r.kind = lpd_pkg::KIND_EMPTY;
          return 1'b1;
        end
        body_left = len[lpd_pkg::LEN_W-1:0];
        st_phase = lpd_pkg::PH_BODY;
        return 1'b0;
      end
      lpd_pkg::PH_BODY: begin
        r.kind = lpd_pkg::KIND_BODY;
        r.body_byte = b;
        r.message_id = id;
        r.body_length = len;
        r.last = (body_left <= 31'd1);
        if (body_left != '0) body_left = body_left - 31'd1;
        if (r.last) begin
          body_left = '0;
          st_phase = lpd_pkg::PH_HEADER;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offer one transfer after a random gap, then log what it should yield
  task automatic feed(input lpd_pkg::cmd_e c, input logic [7:0] b,
                      input logic typed = 1'b0, input logic typed_hit = 1'b0,
                      input lpd_pkg::res_t typed_res = '0);
    lpd_pkg::res_t r;
    bit            hit;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= c;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    fed_count++;
    hit = deframe_step(c, b, r);
    if (typed) begin
      hit = typed_hit;
      r = typed_res;
    end
    if (hit) due_results.push_back(r);
  endtask

  // Drop valid, wait for every due result, then wait out the settle margin
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input lpd_pkg::cfg_reg_e idx,
                           input logic [lpd_pkg::LEN_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == lpd_pkg::CFG_IDLE_LIMIT) idle_lim = v[7:0];
    else max_len = v;
  endtask

  // Send a header, then the body when the length is acceptable; sprinkle ticks
  task automatic send_frame(input logic [31:0] len, input logic [31:0] id);
    logic [63:0] hdr_bytes;
    hdr_bytes = {id, len};
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(11) == 0) feed(lpd_pkg::CMD_TICK, 8'($urandom_range(255)));
      feed(lpd_pkg::CMD_BYTE, hdr_bytes[8*k +: 8]);
    end
    if (len <= {1'b0, max_len}) begin
      for (int unsigned k = 0; k < len; k++) begin
        if ($urandom_range(11) == 0) feed(lpd_pkg::CMD_TICK, 8'($urandom_range(255)));
        feed(lpd_pkg::CMD_BYTE, 8'($urandom_range(255)));
      end
    end
  endtask

  // Check each result transfer and pick the next stall
  always @(posedge clk_i) begin : result_side
    lpd_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $error("result with none due: kind %0d", kind_o);
        error_count++;
      end else begin
        want = due_results.pop_front();
        if (want.kind != kind_o) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          error_count++;
        end
        if (want.body_byte != body_byte_o) begin
          $error("body_byte: expected %h, got %h", want.body_byte, body_byte_o);
          error_count++;
        end
        if (want.message_id != message_id_o) begin
          $error("message_id: expected %h, got %h", want.message_id, message_id_o);
          error_count++;
        end
        if (want.body_length != body_length_o) begin
          $error("body_length: expected %h, got %h", want.body_length, body_length_o);
          error_count++;
        end
        if (want.last != last_o) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          error_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned cap;
    logic [31:0] len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script, starting at reset settings, no idling
    foreach (script_rows[i]) begin
      if (script_rows[i].op == ROW_CFG) begin
        settle();
        write_reg(script_rows[i].reg_sel, script_rows[i].arg);
      end else begin
        feed((script_rows[i].op == ROW_TICK) ? lpd_pkg::CMD_TICK : lpd_pkg::CMD_BYTE,
             script_rows[i].arg[7:0], script_rows[i].typed, script_rows[i].hit,
             script_rows[i].want);
      end
    end

    // Well-formed frames with random content under several settings
    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(lpd_pkg::CFG_IDLE_LIMIT, 31'(lim_set[p]));
      write_reg(lpd_pkg::CFG_MAX_BODY_LEN, 31'(max_set[p]));
      gap_pct = gap_modes[p % 4];
      stall_pct = stall_modes[p % 4];
      target = fed_count + 180;
      while (fed_count < target) begin
        cap = (max_len < 31'd64) ? 32'(max_len) : 24;
        len = ($urandom_range(7) == 0) ? cap : $urandom_range(cap);
        send_frame(len, $urandom());
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(32'(idle_lim) + 2))
            feed(lpd_pkg::CMD_TICK, 8'($urandom_range(255)));
        end
      end
    end

    // Negative length trips the oversize error; everything after is dropped
    settle();
    write_reg(lpd_pkg::CFG_MAX_BODY_LEN, 31'h7FFF_FFFF);
    write_reg(lpd_pkg::CFG_IDLE_LIMIT, 31'd3);
    gap_pct = 22;
    stall_pct = 22;
    send_frame(32'h8000_0000 | $urandom(), $urandom());
    target = fed_count + 150;
    while (fed_count < target) begin
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(5)) feed(lpd_pkg::CMD_TICK, 8'($urandom_range(255)));
      end else begin
        feed(lpd_pkg::CMD_BYTE, 8'($urandom_range(255)));
      end
    end

    settle();
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
